### sv/ssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and functions for the serial seven-segment driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int MAX_DIGITS = 8;
	localparam int DIGIT_W    = 4;
	localparam int WORD_W     = 16;

	localparam logic [7:0] DOT_MASK    = 8'h7F;
	localparam logic [7:0] SELECT_BASE = 8'h01;

	// 16-bit divide by ten: q = (v * RECIP_10) >> RECIP_SHIFT, exact for all 16-bit v
	localparam logic [15:0] RECIP_10    = 16'hCCCD;
	localparam int          RECIP_SHIFT = 19;

	typedef struct packed {
		logic [15:0]                            value;
		logic [1:0]                             dot;
		logic [MAX_DIGITS-1:0][DIGIT_W-1:0]     digits;
	} stage_t;

	// largest number that n decimal digits can show
	function automatic logic [31:0] digit_limit(input int n);
		logic [31:0] lim;
		lim = 32'd1;
		for (int k = 0; k < n; k++) begin
			lim = lim * 32'd10;
		end
		return lim - 32'd1;
	endfunction

	// common-anode segment code, active low
	function automatic logic [7:0] seg_code(input logic [DIGIT_W-1:0] d);
		logic [7:0] s;
		case (d)
			4'd0:    s = 8'hC0;
			4'd1:    s = 8'hF9;
			4'd2:    s = 8'hA4;
			4'd3:    s = 8'hB0;
			4'd4:    s = 8'h99;
			4'd5:    s = 8'h92;
			4'd6:    s = 8'h82;
			4'd7:    s = 8'hF8;
			4'd8:    s = 8'h80;
			4'd9:    s = 8'h90;
			default: s = 8'hFF;
		endcase
		return s;
	endfunction

endpackage

### sv/ssd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_req_if
// Request channel: value to show and decimal point position.
// ----------------------------------------------------------------------------
interface ssd_req_if;
	logic        valid;
	logic        ready;
	logic [15:0] value;
	logic [1:0]  dot_position;

	modport source (output valid, output value, output dot_position, input ready);
	modport sink   (input valid, input value, input dot_position, output ready);
endinterface

### sv/ssd_bit_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_bit_if
// Serial bit channel towards the external shift registers.
// ----------------------------------------------------------------------------
interface ssd_bit_if;
	logic       valid;
	logic       ready;
	logic       serial_bit;
	logic [1:0] digit_number;
	logic       latch_pulse;
	logic       last;

	modport source (output valid, output serial_bit, output digit_number,
		output latch_pulse, output last, input ready);
	modport sink   (input valid, input serial_bit, input digit_number,
		input latch_pulse, input last, output ready);
endinterface

### sv/ssd_digit_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_digit_stage
// One pipeline stage: peels the lowest decimal digit off the running value.
// ----------------------------------------------------------------------------
module ssd_digit_stage #(
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  ssd_pkg::stage_t up_data,
	output logic           dn_valid,
	input  logic           dn_ready,
	output ssd_pkg::stage_t dn_data
);

	logic            valid_s1;
	ssd_pkg::stage_t data_s1;
	logic [31:0]     prod;
	logic [15:0]     quot;
	logic [15:0]     rem;
	ssd_pkg::stage_t nxt;

	always_comb begin
		prod = 32'(up_data.value) * 32'(ssd_pkg::RECIP_10);
		quot = 16'(prod >> ssd_pkg::RECIP_SHIFT);
		rem  = up_data.value - ((quot << 3) + (quot << 1));
		nxt  = up_data;
		nxt.value = quot;
		nxt.digits[IDX] = rem[ssd_pkg::DIGIT_W-1:0];
	end

	assign up_ready = ~valid_s1 | dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

### sv/ssd_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_encode
// Maps digits to segment and select bytes and packs the whole frame.
// ----------------------------------------------------------------------------
module ssd_encode #(
	parameter int DIGITS = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     up_valid,
	output logic                     up_ready,
	input  ssd_pkg::stage_t          up_data,
	output logic                     dn_valid,
	input  logic                     dn_ready,
	output logic [DIGITS*16-1:0]     dn_frame
);

	localparam int FRAME_W = DIGITS * ssd_pkg::WORD_W;

	logic               valid_s1;
	logic [FRAME_W-1:0] frame_s1;
	logic [FRAME_W-1:0] frame;

	// digit 0 sits at the top so it leaves first
	always_comb begin
		frame = '0;
		for (int d = 0; d < DIGITS; d++) begin
			logic [7:0] seg;
			logic [7:0] sel;
			seg = ssd_pkg::seg_code(up_data.digits[d]);
			if (up_data.dot != 2'd0 && 32'(up_data.dot) == d) begin
				seg = seg & ssd_pkg::DOT_MASK;
			end
			sel = ssd_pkg::SELECT_BASE << d;
			frame[(DIGITS-d)*ssd_pkg::WORD_W-1 -: ssd_pkg::WORD_W] = {seg, sel};
		end
	end

	assign up_ready = ~valid_s1 | dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			frame_s1 <= frame;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_frame = frame_s1;

endmodule

### sv/ssd_serialiser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_serialiser
// Shifts a packed frame out one bit per transfer, MSB first.
// ----------------------------------------------------------------------------
module ssd_serialiser #(
	parameter int DIGITS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  logic [DIGITS*16-1:0] up_frame,
	ssd_bit_if.source            disp
);

	localparam int FRAME_W = DIGITS * ssd_pkg::WORD_W;

	logic               busy_q;
	logic [FRAME_W-1:0] frame_q;
	logic [3:0]         bit_q;
	logic [2:0]         dig_q;
	logic               word_end;
	logic               frame_end;
	logic               xfer;

	assign word_end  = (bit_q == 4'd15);
	assign frame_end = word_end && (dig_q == 3'(DIGITS - 1));
	assign xfer      = disp.valid && disp.ready;
	// next frame loads straight behind the final bit
	assign up_ready  = ~busy_q | (xfer & frame_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q  <= '0;
			dig_q  <= '0;
		end else if (up_ready) begin
			busy_q <= up_valid;
			bit_q  <= '0;
			dig_q  <= '0;
		end else if (xfer) begin
			bit_q <= bit_q + 4'd1;
			if (word_end) begin
				dig_q <= dig_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			frame_q <= up_frame;
		end else if (xfer) begin
			frame_q <= {frame_q[FRAME_W-2:0], 1'b0};
		end
	end

	assign disp.valid        = busy_q;
	assign disp.serial_bit   = frame_q[FRAME_W-1];
	assign disp.digit_number = dig_q[1:0];
	assign disp.latch_pulse  = word_end;
	assign disp.last         = frame_end;

endmodule

### sv/seven_segment_serial_display.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_serial_display
// Saturates a value, splits it into decimal digits and streams segment and
// select bytes for a chain of serial shift registers.
// ----------------------------------------------------------------------------
//  channel  dir  transfer carries
//  req      in   value[15:0], dot_position[1:0]
//  disp     out  serial_bit, digit_number[1:0], latch_pulse, last
//
//  Each request gives DIGITS*16 bit transfers (64 by default); the serialiser
//  sends one bit per cycle while disp is ready, loading each new frame
//  behind the final bit. Requests pass saturation, digit and encode stages.
//  Reset clears the valid bits of every stage and the serialiser.
//  A stall on disp holds the current bit; the stages behind fill and then
//  stop taking requests, nothing is lost or sent twice.
// ----------------------------------------------------------------------------
module seven_segment_serial_display #(
	parameter int DIGITS = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	ssd_req_if.sink   req,
	ssd_bit_if.source disp
);

	localparam logic [31:0] LIMIT = ssd_pkg::digit_limit(DIGITS);

	logic            stage_valid [0:DIGITS];
	logic            stage_ready [0:DIGITS];
	ssd_pkg::stage_t stage_data  [0:DIGITS];

	logic            sat_valid_s1;
	ssd_pkg::stage_t sat_data_s1;
	ssd_pkg::stage_t sat_nxt;

	logic                 enc_valid;
	logic                 enc_ready;
	logic [DIGITS*16-1:0] enc_frame;

	always_comb begin
		sat_nxt        = '0;
		sat_nxt.value  = (32'(req.value) > LIMIT) ? LIMIT[15:0] : req.value;
		sat_nxt.dot    = req.dot_position;
	end

	assign req.ready = ~sat_valid_s1 | stage_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_valid_s1 <= 1'b0;
		end else if (req.ready) begin
			sat_valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			sat_data_s1 <= sat_nxt;
		end
	end

	assign stage_valid[0] = sat_valid_s1;
	assign stage_data[0]  = sat_data_s1;

	for (genvar k = 0; k < DIGITS; k++) begin : g_digit
		ssd_digit_stage #(
			.IDX(k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (stage_valid[k]),
			.up_ready (stage_ready[k]),
			.up_data  (stage_data[k]),
			.dn_valid (stage_valid[k+1]),
			.dn_ready (stage_ready[k+1]),
			.dn_data  (stage_data[k+1])
		);
	end

	ssd_encode #(
		.DIGITS(DIGITS)
	) u_encode (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (stage_valid[DIGITS]),
		.up_ready (stage_ready[DIGITS]),
		.up_data  (stage_data[DIGITS]),
		.dn_valid (enc_valid),
		.dn_ready (enc_ready),
		.dn_frame (enc_frame)
	);

	ssd_serialiser #(
		.DIGITS(DIGITS)
	) u_serialiser (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (enc_valid),
		.up_ready (enc_ready),
		.up_frame (enc_frame),
		.disp     (disp)
	);

	// the frame's final bit always ends a digit
	a_last_latch: assert property (@(posedge clk) disable iff (!arst_n)
		disp.valid && disp.last |-> disp.latch_pulse)
		else $error("last without latch_pulse");

	// a frame is sent without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		disp.valid && disp.ready && !disp.last |=> disp.valid)
		else $error("gap inside a frame");

	// after a latch the next digit follows
	a_digit_step: assert property (@(posedge clk) disable iff (!arst_n)
		disp.valid && disp.ready && disp.latch_pulse && !disp.last |=>
		disp.digit_number == 2'($past(disp.digit_number) + 2'd1))
		else $error("digit number did not advance");

	// first bit of a frame is digit zero
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		disp.valid && disp.ready && disp.last |=>
		!disp.valid || disp.digit_number == 2'd0)
		else $error("frame did not start at digit zero");

endmodule

### tb/sv/seven_segment_serial_display_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_serial_display_test
// Drives display requests into the serial seven-segment driver and checks
// every bit transfer against an independent frame predictor. Both channels
// idle in random bursts; the tail of the run is back-to-back.
// ----------------------------------------------------------------------------
module seven_segment_serial_display_test;

	localparam int          N_DIGITS    = 4;
	localparam logic [15:0] DISPLAY_MAX = 16'd9999;
	localparam logic [7:0]  DOT_CLEAR   = 8'h7F;
	localparam logic [7:0]  SELECT_LSB  = 8'h01;
	localparam int          N_RANDOM    = 100;
	localparam int          CALM_TAIL   = 15;

	// common-anode codes for 0..9, active low
	localparam logic [7:0] SEG_CODES [10] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
	};

	typedef struct {
		logic [15:0] value;
		logic [1:0]  dot;
		bit          drain;   // hold back until every outstanding bit has arrived
		bit          idle_ok; // random gaps allowed before this request
	} show_req_t;

	typedef struct {
		logic       serial_bit;
		logic [1:0] digit;
		logic       latch;
		logic       last;
	} frame_bit_t;

	logic clk = 1'b0;
	logic arst_n;

	ssd_req_if req ();
	ssd_bit_if disp ();

	seven_segment_serial_display #(.DIGITS(N_DIGITS)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.disp   (disp)
	);

	always #1 clk = ~clk;

	show_req_t  pending_reqs [$];
	frame_bit_t expected_bits [$];
	int         mismatches = 0;
	int         bits_seen  = 0;
	bit         req_taken  = 1'b0;
	bit         gap_done   = 1'b0;
	bit         tail_calm  = 1'b0;
	int         send_gap   = 0;
	int         stall_left = 0;

	task automatic report_mismatch(input string what);
		$display("mismatch at bit %0d: %s", bits_seen, what);
		mismatches++;
	endtask

	// saturate, split into decimal digits, append the 16 bits of each digit
	task automatic predict_frame(input logic [15:0] value, input logic [1:0] dot);
		logic [15:0] rest;
		logic [7:0]  seg;
		logic [15:0] word;
		frame_bit_t  fb;
		rest = (value > DISPLAY_MAX) ? DISPLAY_MAX : value;
		for (int d = 0; d < N_DIGITS; d++) begin
			seg  = SEG_CODES[rest % 16'd10];
			rest = rest / 16'd10;
			if (dot != 2'd0 && dot == d)
				seg = seg & DOT_CLEAR;
			word = {seg, SELECT_LSB << d};
			for (int k = 0; k < 16; k++) begin
				fb.serial_bit = word[15-k];
				fb.digit      = d[1:0];
				fb.latch      = (k == 15);
				fb.last       = (d == N_DIGITS - 1) && (k == 15);
				expected_bits.push_back(fb);
			end
		end
	endtask

	task automatic queue_req(input logic [15:0] value, input logic [1:0] dot,
		input bit drain, input bit idle_ok);
		show_req_t r;
		r.value   = value;
		r.dot     = dot;
		r.drain   = drain;
		r.idle_ok = idle_ok;
		pending_reqs.push_back(r);
	endtask

	// request side: valid held until the transfer, random gaps between requests
	always @(negedge clk) begin : req_driver
		show_req_t r;
		if (arst_n) begin
			if (req.valid && !req_taken) begin
				// still waiting for the transfer
			end else if (send_gap != 0) begin
				req.valid <= 1'b0;
				send_gap  <= send_gap - 1;
			end else if (pending_reqs.size() != 0 &&
				!(pending_reqs[0].drain && expected_bits.size() != 0)) begin
				if (pending_reqs[0].idle_ok && !gap_done && $urandom_range(0, 3) == 0) begin
					req.valid <= 1'b0;
					send_gap  <= $urandom_range(0, 10);
					gap_done  <= 1'b1;
				end else begin
					r = pending_reqs.pop_front();
					req.valid        <= 1'b1;
					req.value        <= r.value;
					req.dot_position <= r.dot;
					gap_done         <= 1'b0;
					if (!r.idle_ok)
						tail_calm <= 1'b1;
				end
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// bit side: ready drops in random bursts until the calm tail
	always @(negedge clk) begin : disp_stall
		if (arst_n) begin
			if (stall_left != 0) begin
				disp.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!tail_calm && $urandom_range(0, 15) == 0) begin
				disp.ready <= 1'b0;
				stall_left <= $urandom_range(0, 10);
			end else begin
				disp.ready <= 1'b1;
			end
		end
	end

	// check bit transfers first, then predict from a request transfer
	always @(posedge clk) begin : bit_monitor
		frame_bit_t want;
		if (arst_n) begin
			if (disp.valid === 1'b1 && disp.ready === 1'b1) begin
				if (expected_bits.size() == 0) begin
					report_mismatch("bit transfer with nothing expected");
				end else begin
					want = expected_bits.pop_front();
					if (disp.serial_bit !== want.serial_bit)
						report_mismatch($sformatf("serial_bit %b, want %b",
							disp.serial_bit, want.serial_bit));
					if (disp.digit_number !== want.digit)
						report_mismatch($sformatf("digit_number %0d, want %0d",
							disp.digit_number, want.digit));
					if (disp.latch_pulse !== want.latch)
						report_mismatch($sformatf("latch_pulse %b, want %b",
							disp.latch_pulse, want.latch));
					if (disp.last !== want.last)
						report_mismatch($sformatf("last %b, want %b",
							disp.last, want.last));
				end
				bits_seen++;
			end
			if (req.valid === 1'b1 && req.ready === 1'b1)
				predict_frame(req.value, req.dot_position);
			req_taken <= (req.valid === 1'b1 && req.ready === 1'b1);
		end else begin
			req_taken <= 1'b0;
		end
	end

	initial begin : stimulus
		logic [15:0] v;
		req.valid        = 1'b0;
		req.value        = '0;
		req.dot_position = '0;
		disp.ready       = 1'b0;
		arst_n           = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, saturation, every dot position, every digit
		queue_req(16'd0,     2'd0, 1'b0, 1'b1);
		queue_req(16'd9999,  2'd0, 1'b0, 1'b1);
		queue_req(16'd10000, 2'd1, 1'b0, 1'b1);
		queue_req(16'hFFFF,  2'd3, 1'b0, 1'b1);
		queue_req(16'd1234,  2'd1, 1'b0, 1'b1);
		queue_req(16'd5678,  2'd2, 1'b1, 1'b1);
		queue_req(16'd9090,  2'd3, 1'b0, 1'b1);
		queue_req(16'd1,     2'd3, 1'b0, 1'b1);   // dot on a leading zero
		queue_req(16'd8,     2'd2, 1'b0, 1'b1);
		queue_req(16'd9998,  2'd1, 1'b0, 1'b1);
		queue_req(16'h8000,  2'd2, 1'b0, 1'b1);
		queue_req(16'h5555,  2'd1, 1'b0, 1'b1);
		queue_req(16'hAAAA,  2'd2, 1'b0, 1'b1);
		queue_req(16'h0555,  2'd0, 1'b0, 1'b1);
		queue_req(16'h02AA,  2'd3, 1'b0, 1'b1);

		for (int i = 0; i < N_RANDOM; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: v = 16'($urandom_range(0, 9999));
				6:                v = 16'($urandom_range(0, 99));
				7:                v = 16'($urandom_range(10000, 65535));
				8:                v = 16'($urandom_range(9990, 10010));
				default:          v = 16'($urandom);
			endcase
			queue_req(v, 2'($urandom_range(0, 3)), i == N_RANDOM / 2,
				i < N_RANDOM - CALM_TAIL);
		end

		while (pending_reqs.size() != 0 || (req.valid && !req_taken) ||
			expected_bits.size() != 0)
			@(negedge clk);
		repeat (N_DIGITS * 16) @(posedge clk);

		if (expected_bits.size() != 0)
			report_mismatch($sformatf("%0d bits never arrived", expected_bits.size()));
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#1000000;
		$display("timeout");
		$display("status: fail");
		$finish;
	end

endmodule
